// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/rnsa_pkg.sv -----
// Types and constants of the radius nearest site assigner.
package rnsa_pkg;
   localparam int SITE_SLOTS  = 64;
   localparam int GROUP_COUNT = 3;
   localparam int COORD_BITS  = 20;
   localparam int SLOT_W      = (SITE_SLOTS > 1) ? $clog2(SITE_SLOTS) : 1;
   localparam int RADIUS_BITS = COORD_BITS - 1;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int SQ_BITS     = 2 * DIFF_BITS;
   localparam int DIST_BITS   = SQ_BITS + 1;
   localparam int RSQ_BITS    = 2 * RADIUS_BITS;
   localparam int TOTAL_BITS  = 48;
   localparam int COUNT_BITS  = 32;
   localparam int WEIGHT_BITS = 32;
   localparam int KEY_BITS    = 32;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic                          active;
      logic [3:0]                    layer;
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  z;
      logic [RADIUS_BITS-1:0]        radius;
      logic [KEY_BITS-1:0]           key;
      logic [1:0]                    group;
      logic [TOTAL_BITS-1:0]         total;
   } site_type;

   typedef struct packed {
      logic shift;
      logic write;
      logic wb;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic start;
      logic valid;
   } dist_ctl_type;

   typedef struct packed {
      logic                  found;
      logic [SLOT_W-1:0]     slot;
      logic [KEY_BITS-1:0]   key;
      logic [1:0]            group;
      logic [TOTAL_BITS-1:0] total;
   } best_type;
endpackage

// ----- rtl/core/rnsa_if.sv -----
// Request and response channel interfaces.
interface rnsa_req_if;
   import rnsa_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   op;
   logic [5:0]                   site_slot;
   logic                         site_active;
   logic [3:0]                   layer;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_z;
   logic [RADIUS_BITS-1:0]       radius;
   logic [KEY_BITS-1:0]          site_key;
   logic [1:0]                   site_group;
   logic [WEIGHT_BITS-1:0]       weight;
   modport source (output valid, op, site_slot, site_active, layer, pos_x, pos_z,
                   radius, site_key, site_group, weight, input ready);
   modport sink (input valid, op, site_slot, site_active, layer, pos_x, pos_z,
                 radius, site_key, site_group, weight, output ready);
endinterface

interface rnsa_rsp_if;
   import rnsa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  assigned;
   logic [5:0]            hit_slot;
   logic [KEY_BITS-1:0]   hit_key;
   logic [1:0]            hit_group;
   logic [TOTAL_BITS-1:0] site_total;
   logic [TOTAL_BITS-1:0] group_total;
   logic [COUNT_BITS-1:0] unassigned_count;
   logic                  overflow;
   modport source (output valid, assigned, hit_slot, hit_key, hit_group, site_total,
                   group_total, unassigned_count, overflow, input ready);
   modport sink (input valid, assigned, hit_slot, hit_key, hit_group, site_total,
                 group_total, unassigned_count, overflow, output ready);
endinterface

// ----- rtl/core/rnsa_cell.sv -----
// One site cell of the rotating site ring.
module rnsa_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  rnsa_pkg::cell_ctl_type       ctl,
   input  rnsa_pkg::site_type           shift_in,
   input  rnsa_pkg::site_type           wr_site,
   input  logic [rnsa_pkg::TOTAL_BITS-1:0] wb_total,
   output rnsa_pkg::site_type           site
);
   import rnsa_pkg::*;

   site_type site_ff, site_in;

   always_comb begin
      site_in = site_ff;
      if (ctl.shift) begin
         site_in = shift_in;
      end else begin
         if (ctl.write) begin
            site_in.active = wr_site.active;
            site_in.layer  = wr_site.layer;
            site_in.x      = wr_site.x;
            site_in.z      = wr_site.z;
            site_in.radius = wr_site.radius;
            site_in.key    = wr_site.key;
            site_in.group  = wr_site.group;
         end
         if (ctl.wb) begin
            site_in.total = wb_total;
         end
      end
      if (ctl.clear) begin
         site_in.total = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_ff.active <= 1'b0;
         site_ff.total  <= '0;
      end else begin
         site_ff <= site_in;
      end
   end

   assign site = site_ff;
endmodule

// ----- rtl/core/rnsa_dist.sv -----
// Pipelined distance check and running best-site selection.
module rnsa_dist (
   input  logic                                clock,
   input  logic                                reset,
   input  rnsa_pkg::dist_ctl_type              ctl,
   input  rnsa_pkg::site_type                  head,
   input  logic [rnsa_pkg::SLOT_W-1:0]         head_slot,
   input  logic [3:0]                          q_layer,
   input  logic signed [rnsa_pkg::COORD_BITS-1:0] q_x,
   input  logic signed [rnsa_pkg::COORD_BITS-1:0] q_z,
   output rnsa_pkg::best_type                  best
);
   import rnsa_pkg::*;

   // stage 1: eligibility and absolute differences
   logic                         s1_v_ff, s1_elig_ff;
   logic [DIFF_BITS-1:0]         s1_dx_ff, s1_dz_ff;
   logic [RADIUS_BITS-1:0]       s1_rad_ff;
   logic [KEY_BITS-1:0]          s1_key_ff;
   logic [SLOT_W-1:0]            s1_slot_ff;
   logic [1:0]                   s1_grp_ff;
   logic [TOTAL_BITS-1:0]        s1_tot_ff;
   // stage 2: squares
   logic                         s2_v_ff, s2_elig_ff;
   logic [SQ_BITS-1:0]           s2_dx2_ff, s2_dz2_ff;
   logic [RSQ_BITS-1:0]          s2_r2_ff;
   logic [KEY_BITS-1:0]          s2_key_ff;
   logic [SLOT_W-1:0]            s2_slot_ff;
   logic [1:0]                   s2_grp_ff;
   logic [TOTAL_BITS-1:0]        s2_tot_ff;
   // best so far
   best_type                     best_ff;
   logic [DIST_BITS-1:0]         best_d_ff;

   logic signed [DIFF_BITS-1:0]  dx_s, dz_s;
   logic [DIFF_BITS-1:0]         dx_in, dz_in;
   logic                         elig_in;
   logic [DIST_BITS-1:0]         d_sum;
   logic                         take;

   always_comb begin
      dx_s    = DIFF_BITS'(head.x) - DIFF_BITS'(q_x);
      dz_s    = DIFF_BITS'(head.z) - DIFF_BITS'(q_z);
      dx_in   = dx_s[DIFF_BITS-1] ? DIFF_BITS'(-dx_s) : DIFF_BITS'(dx_s);
      dz_in   = dz_s[DIFF_BITS-1] ? DIFF_BITS'(-dz_s) : DIFF_BITS'(dz_s);
      elig_in = head.active && (head.layer == q_layer) && (int'(head.group) < GROUP_COUNT);
      d_sum   = DIST_BITS'(s2_dx2_ff) + DIST_BITS'(s2_dz2_ff);
      take    = s2_v_ff && s2_elig_ff && (d_sum <= DIST_BITS'(s2_r2_ff))
                && (!best_ff.found || (d_sum < best_d_ff)
                    || ((d_sum == best_d_ff) && (s2_key_ff < best_ff.key)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         best_ff.found <= 1'b0;
      end else begin
         s1_v_ff <= ctl.valid;
         s2_v_ff <= s1_v_ff;
         if (ctl.start) begin
            best_ff.found <= 1'b0;
         end else if (take) begin
            best_ff.found <= 1'b1;
         end
      end
      s1_elig_ff <= elig_in;
      s1_dx_ff   <= dx_in;
      s1_dz_ff   <= dz_in;
      s1_rad_ff  <= head.radius;
      s1_key_ff  <= head.key;
      s1_slot_ff <= head_slot;
      s1_grp_ff  <= head.group;
      s1_tot_ff  <= head.total;
      s2_elig_ff <= s1_elig_ff;
      s2_dx2_ff  <= s1_dx_ff * s1_dx_ff;
      s2_dz2_ff  <= s1_dz_ff * s1_dz_ff;
      s2_r2_ff   <= s1_rad_ff * s1_rad_ff;
      s2_key_ff  <= s1_key_ff;
      s2_slot_ff <= s1_slot_ff;
      s2_grp_ff  <= s1_grp_ff;
      s2_tot_ff  <= s1_tot_ff;
      if (take) begin
         best_d_ff     <= d_sum;
         best_ff.slot  <= s2_slot_ff;
         best_ff.key   <= s2_key_ff;
         best_ff.group <= s2_grp_ff;
         best_ff.total <= s2_tot_ff;
      end
   end

   assign best = best_ff;
endmodule

// ----- rtl/core/radius_nearest_store_assigner_unit.sv -----
// Top level: site ring, distance unit, totals and response register.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------
//  req_bus | in  | valid/ready      | op, site slot/active/layer/pos/radius/key
//          |     |                  | /group, weight
//  rsp_bus | out | valid/ready      | assigned, hit slot/key/group, totals,
//          |     |                  | unassigned count, overflow
//
// A query rotates the site ring once past the single distance unit, then the two
// pipeline stages drain in ST_DRAIN, the result commits in ST_FIN and the unit
// returns to ST_IDLE to take the next item.
// Write, clear and none ops go straight to ST_FIN. One item at a time.
// Reset (synchronous) marks all sites inactive and zeroes every total.
// A stalled response holds the commit; the next item is taken once it is loaded.
`include "assert_macros.svh"
module radius_nearest_store_assigner_unit (
   input logic      clock,
   input logic      reset,
   rnsa_req_if.sink   req_bus,
   rnsa_rsp_if.source rsp_bus
);
   import rnsa_pkg::*;

   localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(SITE_SLOTS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   state_type                    state_ff, state_in;
   logic [SLOT_W-1:0]            cnt_ff, cnt_in;
   logic                         drn_ff, drn_in;
   logic                         qry_ff;
   logic [3:0]                   q_layer_ff;
   logic signed [COORD_BITS-1:0] q_x_ff, q_z_ff;
   logic [WEIGHT_BITS-1:0]       q_w_ff;
   logic [TOTAL_BITS-1:0]        grp_tot_ff [GROUP_COUNT];
   logic [COUNT_BITS-1:0]        ucnt_ff, ucnt_in;

   logic                         rsp_valid_ff;
   logic                         rsp_assigned_ff, rsp_overflow_ff;
   logic [5:0]                   rsp_slot_ff;
   logic [KEY_BITS-1:0]          rsp_key_ff;
   logic [1:0]                   rsp_group_ff;
   logic [TOTAL_BITS-1:0]        rsp_st_ff, rsp_gt_ff;
   logic [COUNT_BITS-1:0]        rsp_cnt_ff;

   logic                         acc, out_free, fin_go, commit, do_clear;
   logic                         scan_end;
   best_type                     best;
   dist_ctl_type                 dctl;
   site_type                     wr_site;
   site_type                     cell_q [SITE_SLOTS];
   logic [TOTAL_BITS-1:0]        sel_gt;
   logic [TOTAL_BITS:0]          st_sum, gt_sum;
   logic                         tot_ovf, cnt_ovf;
   logic                         assigned_in, overflow_in;
   logic [TOTAL_BITS-1:0]        st_out, gt_out;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign acc      = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fin_go   = (state_ff == ST_FIN) && out_free;
   assign do_clear = acc && (op_type'(req_bus.op) == OP_CLEAR);
   assign scan_end = (state_ff == ST_SCAN) && (cnt_ff == SCAN_LAST);

   // site ring: cell i takes cell i+1 while scanning, cell 0 feeds the unit
   always_comb begin
      wr_site        = '0;
      wr_site.active = req_bus.site_active;
      wr_site.layer  = req_bus.layer;
      wr_site.x      = req_bus.pos_x;
      wr_site.z      = req_bus.pos_z;
      wr_site.radius = req_bus.radius;
      wr_site.key    = req_bus.site_key;
      wr_site.group  = req_bus.site_group;
   end

   for (genvar i = 0; i < SITE_SLOTS; i++) begin : g_ring
      localparam int NXT = (i + 1) % SITE_SLOTS;
      cell_ctl_type ctl;
      always_comb begin
         ctl.shift = (state_ff == ST_SCAN);
         ctl.write = acc && (op_type'(req_bus.op) == OP_WRITE)
                     && (int'(req_bus.site_slot) == i);
         ctl.wb    = commit && (int'(best.slot) == i);
         ctl.clear = do_clear;
      end
      rnsa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .shift_in (cell_q[NXT]),
         .wr_site  (wr_site),
         .wb_total (st_out),
         .site     (cell_q[i])
      );
   end

   assign dctl.start = acc && (op_type'(req_bus.op) == OP_QUERY);
   assign dctl.valid = (state_ff == ST_SCAN);

   rnsa_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dctl),
      .head      (cell_q[0]),
      .head_slot (cnt_ff),
      .q_layer   (q_layer_ff),
      .q_x       (q_x_ff),
      .q_z       (q_z_ff),
      .best      (best)
   );

   // commit math: totals held on overflow, saturating unassigned count
   always_comb begin
      sel_gt = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         if (int'(best.group) == g) begin
            sel_gt = grp_tot_ff[g];
         end
      end
      st_sum      = {1'b0, best.total} + (TOTAL_BITS + 1)'(q_w_ff);
      gt_sum      = {1'b0, sel_gt} + (TOTAL_BITS + 1)'(q_w_ff);
      tot_ovf     = st_sum[TOTAL_BITS] || gt_sum[TOTAL_BITS];
      cnt_ovf     = (ucnt_ff == COUNT_MAX);
      st_out      = tot_ovf ? best.total : st_sum[TOTAL_BITS-1:0];
      gt_out      = tot_ovf ? sel_gt : gt_sum[TOTAL_BITS-1:0];
      assigned_in = 1'b0;
      overflow_in = 1'b0;
      ucnt_in     = ucnt_ff;
      if (qry_ff) begin
         if (best.found) begin
            assigned_in = !tot_ovf;
            overflow_in = tot_ovf;
         end else begin
            overflow_in = cnt_ovf;
            if (!cnt_ovf) begin
               ucnt_in = ucnt_ff + 1'b1;
            end
         end
      end
   end

   assign commit = fin_go && qry_ff && best.found && !tot_ovf;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      drn_in   = drn_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cnt_in = '0;
               state_in = (op_type'(req_bus.op) == OP_QUERY) ? ST_SCAN : ST_FIN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SCAN_LAST) begin
               drn_in   = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drn_in = 1'b1;
            if (drn_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         drn_ff       <= 1'b0;
         ucnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GROUP_COUNT; g++) begin
            grp_tot_ff[g] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         drn_ff   <= drn_in;
         if (do_clear) begin
            ucnt_ff <= '0;
            for (int g = 0; g < GROUP_COUNT; g++) begin
               grp_tot_ff[g] <= '0;
            end
         end else if (fin_go) begin
            ucnt_ff <= ucnt_in;
            if (commit) begin
               for (int g = 0; g < GROUP_COUNT; g++) begin
                  if (int'(best.group) == g) begin
                     grp_tot_ff[g] <= gt_out;
                  end
               end
            end
         end
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (acc) begin
         qry_ff     <= (op_type'(req_bus.op) == OP_QUERY);
         q_layer_ff <= req_bus.layer;
         q_x_ff     <= req_bus.pos_x;
         q_z_ff     <= req_bus.pos_z;
         q_w_ff     <= req_bus.weight;
      end
      if (fin_go) begin
         rsp_assigned_ff <= assigned_in;
         rsp_overflow_ff <= overflow_in;
         rsp_cnt_ff      <= ucnt_in;
         if (qry_ff && best.found) begin
            rsp_slot_ff  <= 6'(best.slot);
            rsp_key_ff   <= best.key;
            rsp_group_ff <= best.group;
            rsp_st_ff    <= st_out;
            rsp_gt_ff    <= gt_out;
         end else begin
            rsp_slot_ff  <= '0;
            rsp_key_ff   <= '0;
            rsp_group_ff <= '0;
            rsp_st_ff    <= '0;
            rsp_gt_ff    <= '0;
         end
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.assigned         = rsp_assigned_ff;
   assign rsp_bus.hit_slot         = rsp_slot_ff;
   assign rsp_bus.hit_key          = rsp_key_ff;
   assign rsp_bus.hit_group        = rsp_group_ff;
   assign rsp_bus.site_total       = rsp_st_ff;
   assign rsp_bus.group_total      = rsp_gt_ff;
   assign rsp_bus.unassigned_count = rsp_cnt_ff;
   assign rsp_bus.overflow         = rsp_overflow_ff;

   `ASSERT_IMPLIES(a_assigned_no_ovf, clock, reset, rsp_valid_ff && rsp_assigned_ff, !rsp_overflow_ff)
   `ASSERT_NEXT(a_scan_len, clock, reset, scan_end, state_ff == ST_DRAIN)
   `ASSERT_NEXT(a_fin_load, clock, reset, fin_go, rsp_valid_ff && (state_ff == ST_IDLE))
endmodule
